/* design/ppp_pkg.sv */
package ppp_pkg;

  // Field and datapath widths
  localparam int PT_W    = 16;  // input coordinate, Q8.8
  localparam int ROT_W   = 16;  // rotation entry, Q2.14
  localparam int TR_W    = 18;  // translation entry, Q10.8
  localparam int ACC_W   = 35;  // row sum in Q.22
  localparam int FRAC_SH = 14;  // Q.22 to Q.8
  localparam int COORD_W = 21;  // camera coordinate in Q.8
  localparam int FOC_W   = 16;  // focal length / principal point, Q12.4
  localparam int PROD_W  = 38;  // focal length times coordinate
  localparam int NUM_W   = 36;  // dividend magnitude and quotient
  localparam int DIV_W   = 20;  // divisor (positive depth)
  localparam int UV_W    = 20;  // pixel coordinate, Q16.4
  localparam int DEPTH_W = 18;  // depth field, Q10.8
  localparam int FIN_W   = 38;  // signed quotient plus principal point

  localparam int CFG_W   = 54;
  localparam int ADDR_W  = 3;

  // Register indexes of the configuration port
  typedef enum logic [ADDR_W-1:0] {
    REG_ROT_ROW0    = 3'd0,
    REG_ROT_ROW1    = 3'd1,
    REG_ROT_ROW2    = 3'd2,
    REG_TRANSLATION = 3'd3,
    REG_FOCAL       = 3'd4,
    REG_PRINCIPAL   = 3'd5
  } ppp_reg_t;

  // Decoded configuration, entry 3*row+col of rot
  typedef struct packed {
    logic [8:0][ROT_W-1:0] rot;
    logic [2:0][TR_W-1:0]  trans;
    logic [FOC_W-1:0]      fx;
    logic [FOC_W-1:0]      fy;
    logic [FOC_W-1:0]      cx;
    logic [FOC_W-1:0]      cy;
  } ppp_cfg_t;

  // Per-item side data that travels with the division
  typedef struct packed {
    logic [DIV_W-1:0]   d;
    logic               neg_u;
    logic               neg_v;
    logic [DEPTH_W-1:0] depth;
    logic               behind;
  } ppp_meta_t;

  // Dividend pair and side data handed to the divider
  typedef struct packed {
    logic [NUM_W-1:0] num_u;
    logic [NUM_W-1:0] num_v;
    ppp_meta_t        meta;
  } ppp_div_in_t;

  // Saturate a camera coordinate to the depth field
  function automatic logic [DEPTH_W-1:0] sat_depth(logic signed [COORD_W-1:0] v);
    logic signed [COORD_W-1:0] hi;
    logic signed [COORD_W-1:0] lo;
    hi = COORD_W'((1 << (DEPTH_W - 1)) - 1);
    lo = -hi - COORD_W'(1);
    if (v > hi) return hi[DEPTH_W-1:0];
    else if (v < lo) return lo[DEPTH_W-1:0];
    else return v[DEPTH_W-1:0];
  endfunction

  // Saturate a final pixel sum to the pixel field
  function automatic logic [UV_W-1:0] sat_uv(logic signed [FIN_W-1:0] v);
    logic signed [FIN_W-1:0] hi;
    logic signed [FIN_W-1:0] lo;
    hi = FIN_W'((1 << (UV_W - 1)) - 1);
    lo = -hi - FIN_W'(1);
    if (v > hi) return hi[UV_W-1:0];
    else if (v < lo) return lo[UV_W-1:0];
    else return v[UV_W-1:0];
  endfunction

  // One restoring division step: returns {remainder, shifted dividend/quotient}
  function automatic logic [DIV_W+NUM_W-1:0] div_step(logic [DIV_W-1:0] rem,
                                                      logic [NUM_W-1:0] nq,
                                                      logic [DIV_W-1:0] d);
    logic [DIV_W:0]   remw;
    logic             ge;
    logic [DIV_W:0]   diff;
    remw = {rem, nq[NUM_W-1]};
    ge   = (remw >= {1'b0, d});
    diff = remw - {1'b0, d};
    return {(ge ? diff[DIV_W-1:0] : remw[DIV_W-1:0]), nq[NUM_W-2:0], ge};
  endfunction

endpackage

/* design/ppp_xform.sv */
module ppp_xform
  import ppp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  ppp_cfg_t                 cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0][PT_W-1:0]     pt,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0][COORD_W-1:0]  coord
);

  logic                             v1_r, v2_r;
  logic                             rdy1, rdy2;
  logic signed [2*PT_W-1:0]         prod_r [9];
  logic signed [2*PT_W-1:0]         prod_nxt [9];
  logic [2:0][COORD_W-1:0]          coord_r, coord_nxt;

  // Stall chain: a stage moves when empty or when its successor moves
  assign rdy2      = !v2_r || out_ready;
  assign rdy1      = !v1_r || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v2_r;
  assign coord     = coord_r;

  // Stage 1: nine matrix products
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt[3*r+c] = $signed(cfg.rot[3*r+c]) * $signed(pt[c]);
      end
    end
  end

  // Stage 2: row sums plus translation, round half up to Q.8
  always_comb begin
    logic signed [ACC_W-1:0] acc;
    for (int r = 0; r < 3; r++) begin
      acc = ACC_W'(prod_r[3*r]) + ACC_W'(prod_r[3*r+1]) + ACC_W'(prod_r[3*r+2])
          + (ACC_W'($signed(cfg.trans[r])) <<< FRAC_SH)
          + ACC_W'(1 << (FRAC_SH - 1));
      coord_nxt[r] = acc[ACC_W-1:FRAC_SH];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
    if (rdy1 && in_valid) begin
      for (int i = 0; i < 9; i++) prod_r[i] <= prod_nxt[i];
    end
    if (rdy2 && v1_r) coord_r <= coord_nxt;
  end

endmodule

/* design/ppp_scale.sv */
module ppp_scale
  import ppp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  ppp_cfg_t                 cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0][COORD_W-1:0]  coord,
  output logic                     out_valid,
  input  logic                     out_ready,
  output ppp_div_in_t              out_data
);

  logic                      v1_r, v2_r;
  logic                      rdy1, rdy2;
  logic signed [PROD_W-1:0]  pu_r, pv_r;
  logic [DIV_W-1:0]          d_r;
  logic [DEPTH_W-1:0]        depth_r;
  logic                      behind_r;
  logic signed [COORD_W-1:0] zr;
  ppp_div_in_t               dat_r, dat_nxt;

  assign rdy2      = !v2_r || out_ready;
  assign rdy1      = !v1_r || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v2_r;
  assign out_data  = dat_r;
  assign zr        = $signed(coord[2]);

  // Stage 2: sign and magnitude, add half the divisor for rounding
  always_comb begin
    logic [PROD_W-1:0] mu, mv;
    mu = pu_r[PROD_W-1] ? PROD_W'(-pu_r) : PROD_W'(pu_r);
    mv = pv_r[PROD_W-1] ? PROD_W'(-pv_r) : PROD_W'(pv_r);
    dat_nxt.num_u       = mu[NUM_W-1:0] + NUM_W'(d_r >> 1);
    dat_nxt.num_v       = mv[NUM_W-1:0] + NUM_W'(d_r >> 1);
    dat_nxt.meta.d      = d_r;
    dat_nxt.meta.neg_u  = pu_r[PROD_W-1];
    dat_nxt.meta.neg_v  = pv_r[PROD_W-1];
    dat_nxt.meta.depth  = depth_r;
    dat_nxt.meta.behind = behind_r;
  end

  // Stage 1: focal length products, depth and behind test
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
    if (rdy1 && in_valid) begin
      pu_r     <= PROD_W'($signed({1'b0, cfg.fx})) * PROD_W'($signed(coord[0]));
      pv_r     <= PROD_W'($signed({1'b0, cfg.fy})) * PROD_W'($signed(coord[1]));
      d_r      <= coord[2][DIV_W-1:0];
      depth_r  <= sat_depth(zr);
      behind_r <= (zr <= COORD_W'(0));
    end
    if (rdy2 && v1_r) dat_r <= dat_nxt;
  end

endmodule

/* design/ppp_div.sv */
module ppp_div
  import ppp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ppp_div_in_t       in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [NUM_W-1:0]  quo_u,
  output logic [NUM_W-1:0]  quo_v,
  output ppp_meta_t         out_meta
);

  // One quotient bit per stage for both lanes
  logic               v_r     [NUM_W];
  logic               rdy     [NUM_W];
  logic [NUM_W-1:0]   nqu_r   [NUM_W];
  logic [NUM_W-1:0]   nqv_r   [NUM_W];
  logic [DIV_W-1:0]   remu_r  [NUM_W];
  logic [DIV_W-1:0]   remv_r  [NUM_W];
  ppp_meta_t          meta_r  [NUM_W];
  logic [DIV_W+NUM_W-1:0] su_nxt [NUM_W];
  logic [DIV_W+NUM_W-1:0] sv_nxt [NUM_W];

  // Stall chain from the last stage back to the input
  always_comb begin
    rdy[NUM_W-1] = !v_r[NUM_W-1] || out_ready;
    for (int i = NUM_W - 2; i >= 0; i--) rdy[i] = !v_r[i] || rdy[i+1];
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NUM_W-1];
  assign quo_u     = nqu_r[NUM_W-1];
  assign quo_v     = nqv_r[NUM_W-1];
  assign out_meta  = meta_r[NUM_W-1];

  // Division steps, stage 0 starts from a zero remainder
  always_comb begin
    su_nxt[0] = div_step('0, in_data.num_u, in_data.meta.d);
    sv_nxt[0] = div_step('0, in_data.num_v, in_data.meta.d);
    for (int i = 1; i < NUM_W; i++) begin
      su_nxt[i] = div_step(remu_r[i-1], nqu_r[i-1], meta_r[i-1].d);
      sv_nxt[i] = div_step(remv_r[i-1], nqv_r[i-1], meta_r[i-1].d);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_W; i++) v_r[i] <= 1'b0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NUM_W; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
    if (rdy[0] && in_valid) begin
      {remu_r[0], nqu_r[0]} <= su_nxt[0];
      {remv_r[0], nqv_r[0]} <= sv_nxt[0];
      meta_r[0]             <= in_data.meta;
    end
    for (int i = 1; i < NUM_W; i++) begin
      if (rdy[i] && v_r[i-1]) begin
        {remu_r[i], nqu_r[i]} <= su_nxt[i];
        {remv_r[i], nqv_r[i]} <= sv_nxt[i];
        meta_r[i]             <= meta_r[i-1];
      end
    end
  end

endmodule

/* design/pinhole_point_projection.sv */
// Pinhole point projection.
// Input stream: one world point per transfer on in_tdata (x, y, z, signed
// Q8.8). Output stream: one result per point on out_tdata (u, v in signed
// Q16.4 and depth in signed Q10.8, all saturated) with out_tuser set when
// the point lies on or behind the camera plane; u and v are then zero.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (rotation
// rows, translation, focal lengths, principal point). Write only while the
// stream is empty. Unknown indexes are ignored.
// Each point passes through the rotation and translation stages, the focal
// scaling stages, the division pipeline (one quotient bit per stage, both
// pixel axes in parallel) and one output register. Throughput: one point per
// cycle while the receiver keeps out_tready high.
// Reset (synchronous, rst_n low) empties the pipeline and loads the identity
// pose, unit focal lengths and a zero principal point.
// When the receiver holds out_tready low, the pipeline keeps filling its
// empty stages and in_tready falls only once every stage is occupied.
module pinhole_point_projection
  import ppp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [47:0]       in_tdata,   // point_x [15:0], point_y [31:16], point_z [47:32]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,  // u_pixel [19:0], v_pixel [39:20], depth [57:40], zero
  output logic              out_tuser   // behind_camera
);

  logic [3*ROT_W-1:0] rot_r [3];
  logic [3*TR_W-1:0]  trans_r;
  logic [2*FOC_W-1:0] focal_r;
  logic [2*FOC_W-1:0] center_r;
  ppp_cfg_t           cfg;

  logic                     xf_valid, xf_ready;
  logic [2:0][COORD_W-1:0]  xf_coord;
  logic                     sc_valid, sc_ready;
  ppp_div_in_t              sc_data;
  logic                     dv_valid, dv_ready;
  logic [NUM_W-1:0]         quo_u, quo_v;
  ppp_meta_t                dv_meta;

  logic                     out_valid_r;
  logic [UV_W-1:0]          u_r, v_r, u_nxt, v_nxt;
  logic [DEPTH_W-1:0]       depth_r;
  logic                     behind_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0] <= 48'h0000_0000_4000;
      rot_r[1] <= 48'h0000_4000_0000;
      rot_r[2] <= 48'h4000_0000_0000;
      trans_r  <= '0;
      focal_r  <= 32'h0010_0010;
      center_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ROT_ROW0:    rot_r[0] <= cfg_wdata[3*ROT_W-1:0];
        REG_ROT_ROW1:    rot_r[1] <= cfg_wdata[3*ROT_W-1:0];
        REG_ROT_ROW2:    rot_r[2] <= cfg_wdata[3*ROT_W-1:0];
        REG_TRANSLATION: trans_r  <= cfg_wdata[3*TR_W-1:0];
        REG_FOCAL:       focal_r  <= cfg_wdata[2*FOC_W-1:0];
        REG_PRINCIPAL:   center_r <= cfg_wdata[2*FOC_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the register fields
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        cfg.rot[3*r+c] = rot_r[r][ROT_W*c +: ROT_W];
      end
      cfg.trans[r] = trans_r[TR_W*r +: TR_W];
    end
    cfg.fx = focal_r[FOC_W-1:0];
    cfg.fy = focal_r[2*FOC_W-1:FOC_W];
    cfg.cx = center_r[FOC_W-1:0];
    cfg.cy = center_r[2*FOC_W-1:FOC_W];
  end

  ppp_xform u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .pt        (in_tdata),
    .out_valid (xf_valid),
    .out_ready (xf_ready),
    .coord     (xf_coord)
  );

  ppp_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (xf_valid),
    .in_ready  (xf_ready),
    .coord     (xf_coord),
    .out_valid (sc_valid),
    .out_ready (sc_ready),
    .out_data  (sc_data)
  );

  ppp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sc_valid),
    .in_ready  (sc_ready),
    .in_data   (sc_data),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .quo_u     (quo_u),
    .quo_v     (quo_v),
    .out_meta  (dv_meta)
  );

  // Apply sign, add principal point, saturate; zero when behind the camera
  always_comb begin
    logic signed [FIN_W-1:0] qu, qv, su, sv;
    qu = dv_meta.neg_u ? -$signed(FIN_W'(quo_u)) : $signed(FIN_W'(quo_u));
    qv = dv_meta.neg_v ? -$signed(FIN_W'(quo_v)) : $signed(FIN_W'(quo_v));
    su = qu + $signed(FIN_W'(cfg.cx));
    sv = qv + $signed(FIN_W'(cfg.cy));
    u_nxt = dv_meta.behind ? '0 : sat_uv(su);
    v_nxt = dv_meta.behind ? '0 : sat_uv(sv);
  end

  // Output register
  assign dv_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dv_ready) begin
      out_valid_r <= dv_valid;
    end
    if (dv_ready && dv_valid) begin
      u_r      <= u_nxt;
      v_r      <= v_nxt;
      depth_r  <= dv_meta.depth;
      behind_r <= dv_meta.behind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, depth_r, v_r, u_r};
  assign out_tuser  = behind_r;

endmodule
